FILE: design/igcd_pkg.sv
package igcd_pkg;

  // Operand and result width in bits
  localparam int unsigned DATA_WIDTH = 64;
  // Width of the common power-of-two counter
  localparam int unsigned SHIFT_W = $clog2(DATA_WIDTH);

  // Sequencer states of the shared subtract/shift unit
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCALE,
    ST_DONE
  } igcd_state_t;

  // Requests from the channel logic to the core
  typedef struct packed {
    logic start;
    logic take;
  } igcd_ctl_t;

  // Core status back to the channel logic
  typedef struct packed {
    logic idle;
    logic done;
  } igcd_stat_t;

endpackage

FILE: design/igcd_core.sv
module igcd_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  igcd_pkg::igcd_ctl_t              ctl,
  input  logic [igcd_pkg::DATA_WIDTH-1:0]  a_mag,
  input  logic [igcd_pkg::DATA_WIDTH-1:0]  b_mag,
  output igcd_pkg::igcd_stat_t             stat,
  output logic [igcd_pkg::DATA_WIDTH-1:0]  result
);
  import igcd_pkg::*;

  igcd_state_t           state_r, state_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [SHIFT_W-1:0]    k_r, k_nxt;
  logic [DATA_WIDTH:0]   diff;

  // Shared subtractor; the top bit is the borrow
  assign diff = {1'b0, a_r} - {1'b0, b_r};

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

  // Binary GCD sequencer: one shift, swap or subtract per cycle
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          a_nxt     = a_mag;
          b_nxt     = b_mag;
          k_nxt     = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (a_r == '0) begin
          // gcd(0, b) = b, still to be scaled by the common twos
          a_nxt     = b_r;
          state_nxt = ST_SCALE;
        end else if (b_r == '0) begin
          state_nxt = ST_SCALE;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (diff[DATA_WIDTH]) begin
          // a < b: swap so the next subtract is non-negative
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = diff[DATA_WIDTH-1:0];
        end
      end
      ST_SCALE: begin
        // restore the common factor of two, one bit a cycle
        if (k_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          a_nxt = a_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_DONE);
  assign result    = a_r;

endmodule

FILE: design/integer_gcd_unit_top.sv
// Channel | Ports                                   | Direction
// input   | in_valid, in_ready, in_a_value, in_b_value | in
// result  | out_valid, out_ready, out_gcd_result     | out
//
// One beat at a time: the shared subtract/shift unit takes one step a cycle.
// An item is loaded, then reduced by shift, swap and subtract steps (binary
// GCD), then scaled back by the common power of two, and then handed to the
// output register.
// in_ready is high only while the core is idle; a finished result waits in the
// output register, so the next beat can be taken while out_ready is low.
// rst_n is synchronous, active low, and clears the sequencer and out_valid.
module integer_gcd_unit_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [igcd_pkg::DATA_WIDTH-1:0] in_a_value,
  input  logic signed [igcd_pkg::DATA_WIDTH-1:0] in_b_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [igcd_pkg::DATA_WIDTH-1:0]        out_gcd_result
);
  import igcd_pkg::*;

  igcd_ctl_t             ctl;
  igcd_stat_t            stat;
  logic [DATA_WIDTH-1:0] a_mag, b_mag, core_result;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;

  // Magnitudes as unsigned; the most negative value maps to 2^(W-1)
  assign a_mag = in_a_value[DATA_WIDTH-1] ? (~in_a_value + 1'b1) : in_a_value;
  assign b_mag = in_b_value[DATA_WIDTH-1] ? (~in_b_value + 1'b1) : in_b_value;

  assign in_ready  = stat.idle;
  assign ctl.start = in_valid && stat.idle;
  assign ctl.take  = stat.done && (!out_valid_r || out_ready);

  igcd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .a_mag  (a_mag),
    .b_mag  (b_mag),
    .stat   (stat),
    .result (core_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gcd_result = out_data_r;

endmodule

FILE: test/tb_top.sv
module tb_top;
  import igcd_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int RANDOM_ITEMS = 1230;
  localparam int CALM_TAIL = 100;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } operand_pair_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_a_value = '0;
  logic [DW-1:0] in_b_value = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] out_gcd_result;

  operand_pair_t operand_queue[$];
  logic [DW-1:0] gcd_expect[$];
  int            n_items = 0;
  int            n_accepted = 0;
  int            n_sent = 0;
  int            n_errors = 0;
  int            n_cycles = 0;
  int            in_hold = 0;
  int            out_hold = 0;

  integer_gcd_unit_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_a_value    (in_a_value),
    .in_b_value    (in_b_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_gcd_result(out_gcd_result)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gcd of operand magnitudes, Euclid by remainders
  function automatic logic [DW-1:0] gcd_of(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW-1:0] x, y, r;
    x = a[DW-1] ? ~a + 1'b1 : a;
    y = b[DW-1] ? ~b + 1'b1 : b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic logic [DW-1:0] wide_rand();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] maybe_negate(logic [DW-1:0] v);
    logic [DW-1:0] n;
    n = ~v + 1'b1;
    return $urandom_range(0, 1) ? n : v;
  endfunction

  // random operand pair, weighted toward interesting gcds
  function automatic operand_pair_t random_pair();
    operand_pair_t p;
    logic [DW-1:0] g, m;
    int sel, wg, wm;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      p.a = wide_rand();
      p.b = wide_rand();
    end else if (sel < 55) begin
      // shared factor g times two cofactors, no overflow
      wg = $urandom_range(1, DW - 8);
      g = wide_rand() >> (DW - wg);
      wm = $urandom_range(1, DW - 1 - wg);
      m = wide_rand() >> (DW - wm);
      p.a = maybe_negate(g * m);
      wm = $urandom_range(1, DW - 1 - wg);
      m = wide_rand() >> (DW - wm);
      p.b = maybe_negate(g * m);
    end else if (sel < 70) begin
      // common powers of two
      p.a = wide_rand() << $urandom_range(0, DW - 1);
      p.b = wide_rand() << $urandom_range(0, DW - 1);
    end else if (sel < 82) begin
      p.a = maybe_negate(DW'($urandom_range(0, 300)));
      p.b = maybe_negate(DW'($urandom_range(0, 300)));
    end else if (sel < 92) begin
      // one or both operands zero
      p.a = ($urandom_range(0, 7) == 0) ? '0 : wide_rand();
      p.b = '0;
      if ($urandom_range(0, 1)) p = {p.b, p.a};
    end else begin
      case ($urandom_range(0, 4))
        0: p.a = MOST_NEG;
        1: p.a = MOST_POS;
        2: p.a = MOST_NEG + 1'b1;
        3: p.a = maybe_negate(DW'(1) << $urandom_range(0, DW - 1));
        default: p.a = maybe_negate(DW'(1));
      endcase
      p.b = ($urandom_range(0, 1)) ? MOST_NEG : wide_rand();
      if ($urandom_range(0, 1)) p = {p.b, p.a};
    end
    return p;
  endfunction

  task automatic push_pair(logic [DW-1:0] a, logic [DW-1:0] b);
    operand_queue.push_back({a, b});
  endtask

  // no idling near the end, and one calm stretch in every four
  function automatic bit calm();
    return (operand_queue.size() < CALM_TAIL) || ((n_accepted / 150) % 4 == 3);
  endfunction

  // input driver: one beat per pop, held until taken
  always @(negedge clk) begin
    operand_pair_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (n_accepted == n_sent) begin
      if (in_hold > 0) begin
        in_hold--;
        in_valid <= 1'b0;
      end else if (!calm() && $urandom_range(0, 99) < 15) begin
        in_hold = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (operand_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        beat = operand_queue.pop_front();
        n_sent++;
        in_valid <= 1'b1;
        in_a_value <= beat.a;
        in_b_value <= beat.b;
      end
    end
  end

  // result-side backpressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if (!calm() && $urandom_range(0, 99) < 3) begin
      out_hold = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: retire the result beat first, then log the new operand beat
  always @(posedge clk) begin
    logic [DW-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (gcd_expect.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result beat: got %h", out_gcd_result);
        end else begin
          want = gcd_expect.pop_front();
          if (out_gcd_result !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("gcd mismatch: expected %h, got %h", want, out_gcd_result);
          end
        end
      end
      if (in_valid && in_ready) begin
        gcd_expect.push_back(gcd_of(in_a_value, in_b_value));
        n_accepted++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [DW-1:0] fib_lo, fib_hi, fib_t;

    // Fibonacci neighbors: longest remainder chain
    fib_lo = '0;
    fib_hi = DW'(1);
    repeat (91) begin
      fib_t = fib_lo + fib_hi;
      fib_lo = fib_hi;
      fib_hi = fib_t;
    end

    // directed: zeros, extremes, signs, powers of two
    push_pair('0, '0);
    push_pair('0, DW'(5));
    push_pair(-DW'(7), '0);
    push_pair(MOST_NEG, '0);
    push_pair('0, MOST_NEG);
    push_pair(MOST_NEG, MOST_NEG);
    push_pair(MOST_NEG, MOST_POS);
    push_pair(MOST_POS, MOST_POS);
    push_pair(MOST_POS, MOST_NEG + 1'b1);
    push_pair(-DW'(1), MOST_NEG);
    push_pair(DW'(1), DW'(1));
    push_pair(-DW'(1), -DW'(1));
    push_pair(MOST_NEG, DW'(1) << (DW - 2));
    push_pair(MOST_NEG, -DW'(6));
    push_pair(fib_lo, fib_hi);
    push_pair(-fib_hi, fib_lo);
    push_pair(DW'(12), -DW'(18));
    push_pair(-DW'(48), -DW'(180));
    push_pair({(DW/2){2'b10}}, {(DW/2){2'b01}});
    push_pair(DW'(3) << 40, DW'(9) << 20);
    push_pair({DW{1'b1}}, '0);
    push_pair(MOST_POS, DW'(1) << (DW - 2));

    repeat (RANDOM_ITEMS) operand_queue.push_back(random_pair());
    n_items = operand_queue.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_items || gcd_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && gcd_expect.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
